/* design/tcc_pkg.sv */
`default_nettype none
package tcc_pkg;

  localparam int ZW = 26;
  localparam int XW = 34;
  localparam int TW = 18;
  localparam int MW = 16;

  localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = 26'sd2949120;
      1: r = 26'sd1740967;
      2: r = 26'sd919879;
      3: r = 26'sd466945;
      4: r = 26'sd234379;
      5: r = 26'sd117304;
      6: r = 26'sd58666;
      7: r = 26'sd29335;
      8: r = 26'sd14668;
      9: r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/tcc_sample_if.sv */
`default_nettype none
interface tcc_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x_raw;
  logic signed [15:0] accel_y_raw;
  logic signed [15:0] accel_z_raw;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source (output valid, accel_x_raw, accel_y_raw, accel_z_raw, mag_x, mag_y, mag_z,
                  input ready);
  modport sink (input valid, accel_x_raw, accel_y_raw, accel_z_raw, mag_x, mag_y, mag_z,
                output ready);
endinterface
`default_nettype wire

/* design/tcc_angle_if.sv */
`default_nettype none
interface tcc_angle_if;
  logic valid;
  logic ready;
  logic signed [15:0] yaw_deg;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] roll_deg;

  modport source (output valid, yaw_deg, pitch_deg, roll_deg, input ready);
  modport sink (input valid, yaw_deg, pitch_deg, roll_deg, output ready);
endinterface
`default_nettype wire

/* design/tcc_vec.sv */
`default_nettype none
module tcc_vec #(
  parameter int W = 48,
  parameter int N = 16,
  parameter int SW = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [W-1:0]          in_y,
  input  wire logic signed [W-1:0]          in_x,
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [tcc_pkg::ZW-1:0]     out_z,
  output logic [SW-1:0]                     out_side
);

  logic [N:0] v_q;
  logic [N+1:0] rdy;
  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [tcc_pkg::ZW-1:0] z_q [N+1];
  logic [N:0] zero_q;
  logic [SW-1:0] side_q [N+1];

  logic signed [W-1:0] x0_next;
  logic signed [W-1:0] y0_next;
  logic signed [tcc_pkg::ZW-1:0] z0_next;

  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[0];

  always_comb begin
    x0_next = in_x;
    y0_next = in_y;
    z0_next = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_next = in_y;
        y0_next = -in_x;
        z0_next = tcc_pkg::DEG90;
      end else begin
        x0_next = -in_y;
        y0_next = in_x;
        z0_next = -tcc_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      x_q[0] <= x0_next;
      y_q[0] <= y0_next;
      z_q[0] <= z0_next;
      zero_q[0] <= (in_x == '0) && (in_y == '0);
      side_q[0] <= in_side;
    end
  end

  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    localparam int I = k - 1;
    localparam logic signed [tcc_pkg::ZW-1:0] A = tcc_pkg::atan_q16(I);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic up;

    assign dx = y_q[k-1] >>> I;
    assign dy = x_q[k-1] >>> I;
    assign up = y_q[k-1] > 0;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_q[k-1];
      end
      if (rdy[k] && v_q[k-1]) begin
        x_q[k] <= up ? x_q[k-1] + dx : x_q[k-1] - dx;
        y_q[k] <= up ? y_q[k-1] - dy : y_q[k-1] + dy;
        z_q[k] <= up ? z_q[k-1] + A : z_q[k-1] - A;
        zero_q[k] <= zero_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = v_q[N];
  assign out_z = zero_q[N] ? '0 : z_q[N];
  assign out_side = side_q[N];

endmodule
`default_nettype wire

/* design/tcc_rot.sv */
`default_nettype none
module tcc_rot #(
  parameter int N = 16,
  parameter int SW = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [tcc_pkg::ZW-1:0] in_z,
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [tcc_pkg::TW-1:0]     out_sin,
  output logic signed [tcc_pkg::TW-1:0]     out_cos,
  output logic [SW-1:0]                     out_side
);

  localparam int XW = tcc_pkg::XW;
  localparam int ZW = tcc_pkg::ZW;
  localparam int TW = tcc_pkg::TW;

  logic [N:0] v_q;
  logic [N+2:0] rdy;
  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic [N:0] neg_q;
  logic [SW-1:0] side_q [N+1];

  logic signed [ZW-1:0] z0_next;
  logic neg0_next;

  logic fv;
  logic signed [TW-1:0] s_q;
  logic signed [TW-1:0] c_q;
  logic [SW-1:0] fside_q;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [TW-1:0] xt;
  logic signed [TW-1:0] yt;

  assign rdy[N+2] = out_ready;
  assign rdy[N+1] = !fv || rdy[N+2];
  assign in_ready = rdy[0];

  always_comb begin
    z0_next = in_z;
    neg0_next = 1'b0;
    if (in_z > tcc_pkg::DEG90) begin
      z0_next = in_z - tcc_pkg::DEG180;
      neg0_next = 1'b1;
    end else if (in_z < -tcc_pkg::DEG90) begin
      z0_next = in_z + tcc_pkg::DEG180;
      neg0_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      x_q[0] <= tcc_pkg::CORDIC_K;
      y_q[0] <= '0;
      z_q[0] <= z0_next;
      neg_q[0] <= neg0_next;
      side_q[0] <= in_side;
    end
  end

  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    localparam int I = k - 1;
    localparam logic signed [ZW-1:0] A = tcc_pkg::atan_q16(I);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic pos;

    assign dx = y_q[k-1] >>> I;
    assign dy = x_q[k-1] >>> I;
    assign pos = z_q[k-1] >= 0;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_q[k-1];
      end
      if (rdy[k] && v_q[k-1]) begin
        x_q[k] <= pos ? x_q[k-1] - dx : x_q[k-1] + dx;
        y_q[k] <= pos ? y_q[k-1] + dy : y_q[k-1] - dy;
        z_q[k] <= pos ? z_q[k-1] - A : z_q[k-1] + A;
        neg_q[k] <= neg_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign xr = (x_q[N] + XW'(8192)) >>> 14;
  assign yr = (y_q[N] + XW'(8192)) >>> 14;
  assign xt = xr[TW-1:0];
  assign yt = yr[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (rdy[N+1]) begin
      fv <= v_q[N];
    end
    if (rdy[N+1] && v_q[N]) begin
      c_q <= neg_q[N] ? -xt : xt;
      s_q <= neg_q[N] ? -yt : yt;
      fside_q <= side_q[N];
    end
  end

  assign out_valid = fv;
  assign out_sin = s_q;
  assign out_cos = c_q;
  assign out_side = fside_q;

endmodule
`default_nettype wire

/* design/tcc_mag.sv */
`default_nettype none
module tcc_mag #(
  parameter int YW = 56,
  parameter int SW = 52
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [15:0]           mx,
  input  wire logic signed [15:0]           my,
  input  wire logic signed [15:0]           mz,
  input  wire logic signed [tcc_pkg::TW-1:0] sp,
  input  wire logic signed [tcc_pkg::TW-1:0] cp,
  input  wire logic signed [tcc_pkg::TW-1:0] sr,
  input  wire logic signed [tcc_pkg::TW-1:0] cr,
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [YW-1:0]              xc,
  output logic signed [YW-1:0]              yc,
  output logic [SW-1:0]                     out_side
);

  localparam int TW = tcc_pkg::TW;
  localparam int PW = 16 + TW;
  localparam int AW = PW + 1;
  localparam int MW2 = AW + TW;

  logic [3:0] v;
  logic [4:0] rdy;

  logic signed [PW-1:0] p1, p2, p3, p4, p5;
  logic signed [TW-1:0] sr1, sr2;
  logic [SW-1:0] side1, side2, side3, side4;
  logic signed [AW-1:0] a2, b2, a3;
  logic signed [PW-1:0] c2, c3;
  logic signed [MW2-1:0] t3;
  logic signed [YW-1:0] xc4, yc4;

  assign rdy[4] = out_ready;
  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
    if (rdy[0] && in_valid) begin
      p1 <= PW'(mx) * PW'(cp);
      p2 <= PW'(mz) * PW'(sp);
      p3 <= PW'(mx) * PW'(sp);
      p4 <= PW'(mz) * PW'(cp);
      p5 <= PW'(my) * PW'(cr);
      sr1 <= sr;
      side1 <= in_side;
    end
    if (rdy[1] && v[0]) begin
      a2 <= AW'(p1) + AW'(p2);
      b2 <= AW'(p3) - AW'(p4);
      c2 <= p5;
      sr2 <= sr1;
      side2 <= side1;
    end
    if (rdy[2] && v[1]) begin
      t3 <= MW2'(b2) * MW2'(sr2);
      a3 <= a2;
      c3 <= c2;
      side3 <= side2;
    end
    if (rdy[3] && v[2]) begin
      xc4 <= YW'(a3) <<< 16;
      yc4 <= YW'(t3) + (YW'(c3) <<< 16);
      side4 <= side3;
    end
  end

  assign out_valid = v[3];
  assign xc = xc4;
  assign yc = yc4;
  assign out_side = side4;

endmodule
`default_nettype wire

/* design/tilt_compensated_compass.sv */
`default_nettype none
// Tilt-compensated compass: each request carries three accelerometer words and three
// magnetometer words and yields yaw, pitch and roll in signed degrees with
// ANGLE_FRAC_BITS fraction bits, saturated to +-180. Pitch is atan2(ay, az) and roll is
// atan2(ax, az), with the accelerometer words first shifted right by two. The datapath is
// fully pipelined and takes a new request in every cycle unless the output stalls;
// requests pass through the three CORDIC chains in series (tilt angles, sine and cosine,
// heading), the four-stage compensation multiplier and the output register.
module tilt_compensated_compass #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input wire logic clk,
  input wire logic rst,
  tcc_sample_if.sink sample,
  tcc_angle_if.source angle
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int ZW = tcc_pkg::ZW;
  localparam int TW = tcc_pkg::TW;
  localparam int VW = 48;
  localparam int YW = 56;
  localparam int RW = ZW + 1;
  localparam int SH = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] LIM = RW'(180) <<< ANGLE_FRAC_BITS;

  logic signed [VW-1:0] ax_w, ay_w, az_w;

  logic pv_in_ready, rv_in_ready, pv_valid, rv_valid, pv_ready, rv_ready;
  logic signed [ZW-1:0] pitch_z, roll_z;
  logic [31:0] pv_side;
  logic [15:0] rv_side;

  logic rp_in_ready, rr_in_ready, rp_valid, rr_valid, rp_ready, rr_ready;
  logic signed [TW-1:0] sp, cp, sr, cr;
  logic [ZW+31:0] rp_side;
  logic [ZW+15:0] rr_side;

  logic mg_in_ready, mg_valid, mg_ready;
  logic signed [YW-1:0] xc, yc;
  logic [2*ZW-1:0] mg_side;

  logic yv_valid, yv_ready;
  logic signed [ZW-1:0] yaw_z;
  logic [2*ZW-1:0] yv_side;

  logic ov;
  logic signed [15:0] yaw_q, pitch_q, roll_q;

  function automatic logic signed [15:0] to_deg(input logic signed [ZW-1:0] z);
    logic signed [RW-1:0] r;
    r = (RW'(z) + HALF) >>> SH;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[15:0];
  endfunction

  assign ax_w = VW'(sample.accel_x_raw >>> 2) <<< 30;
  assign ay_w = VW'(sample.accel_y_raw >>> 2) <<< 30;
  assign az_w = VW'(sample.accel_z_raw >>> 2) <<< 30;

  assign sample.ready = pv_in_ready && rv_in_ready;

  tcc_vec #(.W(VW), .N(N), .SW(32)) u_pitch_vec (
    .clk(clk), .rst(rst),
    .in_valid(sample.valid && rv_in_ready), .in_ready(pv_in_ready),
    .in_y(ay_w), .in_x(az_w), .in_side({sample.mag_x, sample.mag_y}),
    .out_valid(pv_valid), .out_ready(pv_ready), .out_z(pitch_z), .out_side(pv_side)
  );

  tcc_vec #(.W(VW), .N(N), .SW(16)) u_roll_vec (
    .clk(clk), .rst(rst),
    .in_valid(sample.valid && pv_in_ready), .in_ready(rv_in_ready),
    .in_y(ax_w), .in_x(az_w), .in_side(sample.mag_z),
    .out_valid(rv_valid), .out_ready(rv_ready), .out_z(roll_z), .out_side(rv_side)
  );

  assign pv_ready = rv_valid && rp_in_ready && rr_in_ready;
  assign rv_ready = pv_valid && rp_in_ready && rr_in_ready;

  tcc_rot #(.N(N), .SW(ZW + 32)) u_pitch_rot (
    .clk(clk), .rst(rst),
    .in_valid(pv_valid && rv_valid && rr_in_ready), .in_ready(rp_in_ready),
    .in_z(pitch_z), .in_side({pitch_z, pv_side}),
    .out_valid(rp_valid), .out_ready(rp_ready),
    .out_sin(sp), .out_cos(cp), .out_side(rp_side)
  );

  tcc_rot #(.N(N), .SW(ZW + 16)) u_roll_rot (
    .clk(clk), .rst(rst),
    .in_valid(pv_valid && rv_valid && rp_in_ready), .in_ready(rr_in_ready),
    .in_z(roll_z), .in_side({roll_z, rv_side}),
    .out_valid(rr_valid), .out_ready(rr_ready),
    .out_sin(sr), .out_cos(cr), .out_side(rr_side)
  );

  assign rp_ready = rr_valid && mg_in_ready;
  assign rr_ready = rp_valid && mg_in_ready;

  tcc_mag #(.YW(YW), .SW(2 * ZW)) u_mag (
    .clk(clk), .rst(rst),
    .in_valid(rp_valid && rr_valid), .in_ready(mg_in_ready),
    .mx(rp_side[31:16]), .my(rp_side[15:0]), .mz(rr_side[15:0]),
    .sp(sp), .cp(cp), .sr(sr), .cr(cr),
    .in_side({rp_side[ZW+31:32], rr_side[ZW+15:16]}),
    .out_valid(mg_valid), .out_ready(mg_ready),
    .xc(xc), .yc(yc), .out_side(mg_side)
  );

  tcc_vec #(.W(YW), .N(N), .SW(2 * ZW)) u_yaw_vec (
    .clk(clk), .rst(rst),
    .in_valid(mg_valid), .in_ready(mg_ready),
    .in_y(yc), .in_x(xc), .in_side(mg_side),
    .out_valid(yv_valid), .out_ready(yv_ready), .out_z(yaw_z), .out_side(yv_side)
  );

  assign yv_ready = !ov || angle.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (yv_ready) begin
      ov <= yv_valid;
    end
    if (yv_ready && yv_valid) begin
      yaw_q <= to_deg(yaw_z);
      pitch_q <= to_deg(yv_side[2*ZW-1:ZW]);
      roll_q <= to_deg(yv_side[ZW-1:0]);
    end
  end

  assign angle.valid = ov;
  assign angle.yaw_deg = yaw_q;
  assign angle.pitch_deg = pitch_q;
  assign angle.roll_deg = roll_q;

`ifndef SYNTH
  a_tilt_lockstep: assert property (@(posedge clk) disable iff (rst)
    pv_valid == rv_valid)
    else $error("Pitch and roll vectoring pipelines lost alignment.");

  a_trig_lockstep: assert property (@(posedge clk) disable iff (rst)
    rp_valid == rr_valid)
    else $error("Pitch and roll sine-cosine pipelines lost alignment.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !ov && !yv_valid && !mg_valid)
    else $error("Pipeline holds a request right after reset.");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    ov |-> (yaw_q <= 16'(LIM)) && (yaw_q >= -16'(LIM)))
    else $error("Heading left the saturated range.");
`endif

endmodule
`default_nettype wire
